/* src/huffman_code_bit_packer_macros.svh */
// Assertion helpers shared by the packer blocks.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/hcbp_pkg.sv */
`timescale 1ns / 1ps

package hcbp_pkg;

  // Fixed field widths of the channel words.
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned CODE_IN_W  = 32;
  localparam int unsigned LEN_IN_W   = 6;
  localparam int unsigned BYTE_W     = 8;
  // Leftover bits held between words, and the width of their count.
  localparam int unsigned PEND_W     = 7;
  localparam int unsigned PCNT_W     = 3;

  // Request codes carried by the input word.
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FINISH = 2'd2
  } req_t;

  // Control of the word that has left the table stage.
  typedef struct packed {
    logic vld;
    logic enc;
    logic fin;
  } item_ctl_t;

endpackage

/* src/hcbp_table.sv */
`timescale 1ns / 1ps

`include "huffman_code_bit_packer_macros.svh"

module hcbp_table #(
  parameter int SYMBOL_COUNT = 256,
  parameter int CODE_W       = 32,
  parameter int LEN_W        = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_req_type,
  input  logic [hcbp_pkg::SYM_W-1:0]          in_symbol,
  input  logic [hcbp_pkg::CODE_IN_W-1:0]      in_code_bits,
  input  logic [hcbp_pkg::LEN_IN_W-1:0]       in_code_len,
  input  logic                                take,
  output hcbp_pkg::item_ctl_t                 ctl,
  output logic [CODE_W-1:0]                   code,
  output logic [LEN_W-1:0]                    len
);

  localparam int ADDR_W = $clog2(SYMBOL_COUNT);
  localparam logic [hcbp_pkg::SYM_W:0] SYM_LIM = SYMBOL_COUNT[hcbp_pkg::SYM_W:0];
  localparam logic [hcbp_pkg::LEN_IN_W-1:0] LEN_LIM = CODE_W[hcbp_pkg::LEN_IN_W-1:0];

  logic [CODE_W+LEN_W-1:0]          mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]          vld_r;
  logic [CODE_W+LEN_W-1:0]          rd_r;
  logic                             rd_vld_r;
  logic                             s1_vld_r;
  logic                             enc_r;
  logic                             fin_r;
  logic [ADDR_W-1:0]                addr;
  logic                             in_range;
  logic                             accept;
  logic                             is_load;
  logic [hcbp_pkg::LEN_IN_W-1:0]    len_sat;
  logic [CODE_W-1:0]                code_msk;

  // Decode of the incoming word.
  assign addr     = in_symbol[ADDR_W-1:0];
  assign in_range = {1'b0, in_symbol} < SYM_LIM;
  assign in_stall = s1_vld_r && !take;
  assign accept   = in_valid && !in_stall;
  assign is_load  = in_req_type == hcbp_pkg::REQ_LOAD;

  // Lengths saturate at the table width, and code bits above the length are dropped.
  assign len_sat  = (in_code_len > LEN_LIM) ? LEN_LIM : in_code_len;
  assign code_msk = CODE_W'(in_code_bits) & ~({CODE_W{1'b1}} << len_sat);

  // Code table: one write port for loads, one registered read port for encodes.
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      if (is_load) begin
        mem[addr] <= {LEN_W'(len_sat), code_msk};
      end
      rd_r <= mem[addr];
    end
  end

  // Entry valid bits and the stage register that holds the looked-up word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      enc_r    <= 1'b0;
      fin_r    <= 1'b0;
    end else begin
      if (accept && in_range && is_load) begin
        vld_r[addr] <= 1'b1;
      end
      if (accept) begin
        s1_vld_r <= 1'b1;
        enc_r    <= (in_req_type == hcbp_pkg::REQ_ENCODE) && in_range;
        fin_r    <= in_req_type == hcbp_pkg::REQ_FINISH;
        rd_vld_r <= in_range && vld_r[addr];
      end else if (take) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  // An entry that was never loaded is marked not valid and so yields no bits.
  assign len      = rd_r[CODE_W +: LEN_W];
  assign code     = rd_r[CODE_W-1:0];
  assign ctl.vld  = s1_vld_r;
  assign ctl.enc  = enc_r && rd_vld_r && (len != '0);
  assign ctl.fin  = fin_r;

  `HCBP_ASSERT_NXT(a_stage_holds, s1_vld_r && !take, s1_vld_r && $stable(ctl) && $stable(rd_vld_r), "table stage lost a word under backpressure")
  `HCBP_ASSERT_NXT(a_load_marks, accept && in_range && is_load, vld_r[$past(addr)], "loaded entry not marked valid")

endmodule

/* src/hcbp_packer.sv */
`timescale 1ns / 1ps

`include "huffman_code_bit_packer_macros.svh"

module hcbp_packer #(
  parameter int CODE_W = 32,
  parameter int LEN_W  = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hcbp_pkg::item_ctl_t          ctl,
  input  logic [CODE_W-1:0]            code,
  input  logic [LEN_W-1:0]             len,
  output logic                         take,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_last
);

  localparam int ACC_W = CODE_W + hcbp_pkg::PEND_W;
  localparam int TOT_W = $clog2(ACC_W + 1);
  localparam logic [TOT_W-1:0] TOT_BYTE = TOT_W'(hcbp_pkg::BYTE_W);

  logic [ACC_W-1:0]                acc_r, acc_nxt;
  logic [TOT_W-1:0]                tot_r, tot_nxt;
  logic                            fin_r, fin_nxt;
  logic [hcbp_pkg::PCNT_W-1:0]     fcnt_r, fcnt_nxt;
  logic                            out_valid_r;
  logic [hcbp_pkg::BYTE_W-1:0]     out_byte_r;
  logic                            out_last_r;

  logic                            has_byte;
  logic                            busy;
  logic                            out_free;
  logic                            emit;
  logic [TOT_W-1:0]                tot_left;
  logic [ACC_W-1:0]                shifted;
  logic                            last_now;
  logic                            free_after;
  logic [hcbp_pkg::PCNT_W-1:0]     rtot;
  logic [hcbp_pkg::PEND_W-1:0]     rbits;
  logic                            nop;
  logic                            take_work;

  // Byte extraction: the oldest complete byte sits just above the newer bits.
  assign has_byte = tot_r >= TOT_BYTE;
  assign busy     = has_byte || fin_r;
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = busy && out_free;
  assign tot_left = tot_r - TOT_BYTE;
  assign shifted  = acc_r >> tot_left;
  assign last_now = has_byte ? ((tot_left < TOT_BYTE) && !fin_r) : 1'b1;

  // The accumulator is free for a new word once this cycle's byte is its last.
  assign free_after = !busy || (emit && last_now);

  // Leftover bits as they stand after this cycle's emission.
  always_comb begin
    if (!busy) begin
      rtot = tot_r[hcbp_pkg::PCNT_W-1:0];
    end else if (has_byte) begin
      rtot = tot_left[hcbp_pkg::PCNT_W-1:0];
    end else begin
      rtot = '0;
    end
  end
  assign rbits = acc_r[hcbp_pkg::PEND_W-1:0] & ~({hcbp_pkg::PEND_W{1'b1}} << rtot);

  // Words that change nothing here pass straight through.
  assign nop       = !ctl.enc && !ctl.fin;
  assign take      = ctl.vld && (nop || free_after);
  assign take_work = take && !nop;

  // Accumulator update: emission first, then a newly taken word on top.
  always_comb begin
    acc_nxt  = acc_r;
    tot_nxt  = tot_r;
    fin_nxt  = fin_r;
    fcnt_nxt = fcnt_r;
    if (emit) begin
      if (has_byte) begin
        tot_nxt = tot_left;
      end else begin
        fin_nxt = 1'b0;
      end
    end
    if (take && ctl.enc) begin
      acc_nxt = (ACC_W'(rbits) << len) | ACC_W'(code);
      tot_nxt = TOT_W'(rtot) + TOT_W'(len);
    end else if (take && ctl.fin) begin
      fin_nxt  = 1'b1;
      fcnt_nxt = '0 - rtot;
      if (rtot != '0) begin
        acc_nxt = ACC_W'(hcbp_pkg::BYTE_W'({rbits, 1'b0} << (3'd7 - rtot)));
        tot_nxt = TOT_BYTE;
      end else begin
        tot_nxt = '0;
      end
    end
  end

  // Accumulator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r <= '0;
      fin_r <= 1'b0;
    end else begin
      tot_r <= tot_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    fcnt_r <= fcnt_nxt;
  end

  // Output register parts the accumulator from the downstream stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= has_byte ? shifted[hcbp_pkg::BYTE_W-1:0]
                             : hcbp_pkg::BYTE_W'(fcnt_r);
      out_last_r <= last_now;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  `HCBP_ASSERT_IMP(a_fin_pad, fin_r, (tot_r == '0) || (tot_r == TOT_BYTE), "finish holds more than one padded byte")
  `HCBP_ASSERT_NXT(a_idle_after_last, emit && last_now && !take_work, !busy, "packer still busy after its last byte")

endmodule

/* src/huffman_code_bit_packer.sv */
// Huffman code bit packer: code table lookup followed by an MSB-first byte packer.
// The first byte of a word passes the table stage, the accumulator and the output register.
// Throughput: one byte per cycle while out_stall is low; the accumulator takes the next word
// as the last byte of the current one is emitted.
// Reset (synchronous, rst_n low): all table entries are marked unloaded and no bits pend.
`timescale 1ns / 1ps

module huffman_code_bit_packer #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_req_type,
  input  logic [hcbp_pkg::SYM_W-1:0]         in_symbol,
  input  logic [hcbp_pkg::CODE_IN_W-1:0]     in_code_bits,
  input  logic [hcbp_pkg::LEN_IN_W-1:0]      in_code_len,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_last
);

  // Stored code width is the smaller of the longest code and the input field.
  localparam int CODE_W = (MAX_CODE_LEN > int'(hcbp_pkg::CODE_IN_W))
                          ? int'(hcbp_pkg::CODE_IN_W) : MAX_CODE_LEN;
  localparam int LEN_W  = $clog2(CODE_W + 1);

  hcbp_pkg::item_ctl_t   ctl;
  logic [CODE_W-1:0]     code;
  logic [LEN_W-1:0]      len;
  logic                  take;

  // Table lookup and load.
  hcbp_table #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .CODE_W       (CODE_W),
    .LEN_W        (LEN_W)
  ) u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_symbol    (in_symbol),
    .in_code_bits (in_code_bits),
    .in_code_len  (in_code_len),
    .take         (take),
    .ctl          (ctl),
    .code         (code),
    .len          (len)
  );

  // Bit accumulator and byte output.
  hcbp_packer #(
    .CODE_W    (CODE_W),
    .LEN_W     (LEN_W)
  ) u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .code      (code),
    .len       (len),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import hcbp_pkg::*;

  // Request code that the block must ignore.
  localparam logic [1:0] REQ_UNDEF = 2'd3;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned WORDS_PER_PHASE = 24;
  localparam int unsigned MAX_REPORTS = 10;

  // One packed byte as it leaves the block.
  typedef struct {
    logic [BYTE_W-1:0] value;
    logic last;
  } out_word_t;

  // One input word; typed rows carry their bytes, first byte in the top lane.
  typedef struct {
    logic [1:0] req;
    logic [SYM_W-1:0] sym;
    logic [CODE_IN_W-1:0] bits;
    logic [LEN_IN_W-1:0] len;
    logic typed;
    logic [2:0] n;
    logic [31:0] bytes;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = REQ_LOAD;
  logic [SYM_W-1:0] in_symbol = '0;
  logic [CODE_IN_W-1:0] in_code_bits = '0;
  logic [LEN_IN_W-1:0] in_code_len = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic out_last;

  // Mirror of the code table and the bit accumulator.
  logic [CODE_IN_W-1:0] tbl_code [256];
  logic [LEN_IN_W-1:0] tbl_len [256];
  logic [PEND_W-1:0] acc_bits = '0;
  logic [PCNT_W-1:0] acc_count = '0;

  out_word_t expected_bytes[$];
  logic [SYM_W-1:0] loaded_syms[$];
  stim_row_t directed_rows [24];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit hold_off_req = 1'b0;
  bit sender_gapless = 1'b0;
  bit calm = 1'b0;

  huffman_code_bit_packer i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_symbol    (in_symbol),
    .in_code_bits (in_code_bits),
    .in_code_len  (in_code_len),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  // Work out the bytes that one input word produces and update the mirror.
  function automatic void pack_word(input logic [1:0] req, input logic [SYM_W-1:0] sym,
                                    input logic [CODE_IN_W-1:0] bits,
                                    input logic [LEN_IN_W-1:0] len, output out_word_t res[$]);
    logic [63:0] acc;
    int unsigned total;
    int unsigned nbytes;
    int unsigned clen;
    int unsigned cnt;
    res = {};
    case (req)
      REQ_LOAD: begin
        // Lengths saturate at the code width; bits above the length are dropped.
        clen = (len > CODE_IN_W) ? CODE_IN_W : len;
        tbl_code[sym] = (clen < CODE_IN_W) ? bits & 32'((64'd1 << clen) - 64'd1) : bits;
        tbl_len[sym] = LEN_IN_W'(clen);
      end
      REQ_ENCODE: begin
        if (tbl_len[sym] != 0) begin
          acc = (64'(acc_bits) << tbl_len[sym]) | 64'(tbl_code[sym]);
          total = acc_count + tbl_len[sym];
          nbytes = total / 8;
          for (int k = 0; k < nbytes; k++) begin
            total -= 8;
            res.push_back(out_word_t'{8'(acc >> total), k == nbytes - 1});
          end
          acc_bits = PEND_W'(acc & ((64'd1 << total) - 64'd1));
          acc_count = PCNT_W'(total);
        end
      end
      REQ_FINISH: begin
        // Leftover bits go out zero-padded, then the count of padding bits.
        cnt = acc_count;
        if (cnt != 0) begin
          res.push_back(out_word_t'{8'({1'b0, acc_bits} << (8 - cnt)), 1'b0});
        end
        res.push_back(out_word_t'{8'((8 - cnt) % 8), 1'b1});
        acc_bits = '0;
        acc_count = '0;
      end
      default: begin
      end
    endcase
  endfunction

  // Offer a word until it is taken, then queue the bytes it should produce.
  task automatic send_word(input stim_row_t row);
    out_word_t predicted[$];
    in_valid <= 1'b1;
    in_req_type <= row.req;
    in_symbol <= row.sym;
    in_code_bits <= row.bits;
    in_code_len <= row.len;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pack_word(row.req, row.sym, row.bits, row.len, predicted);
    if (row.typed) begin
      for (int k = 0; k < row.n; k++) begin
        expected_bytes.push_back(out_word_t'{row.bytes[31 - 8 * k -: 8], k == row.n - 1});
      end
    end else begin
      foreach (predicted[k]) expected_bytes.push_back(predicted[k]);
    end
    if (row.req == REQ_LOAD) loaded_syms.push_back(row.sym);
  endtask

  // Random gap on the sending side: mostly none or short, now and then long.
  task automatic rest_sender();
    int unsigned roll;
    int unsigned gap;
    roll = $urandom_range(0, 99);
    gap = 0;
    if (!calm && !sender_gapless) begin
      if (roll >= 95) gap = $urandom_range(10, 40);
      else if (roll >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_req_type <= 2'($urandom);
      in_symbol <= SYM_W'($urandom);
      in_code_bits <= $urandom;
      in_code_len <= LEN_IN_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Let the block drain completely before going on.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void note_mismatch(input string what, input out_word_t want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch (%s) at cycle %0d: expected byte %02h last %0b, got byte %02h last %0b",
               what, cycle_count, want.value, want.last, out_byte, out_last);
    end
  endfunction

  // Compare every byte taken from the block with the oldest one expected.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_bytes.size() == 0) begin
        note_mismatch("nothing expected", out_word_t'{'x, 'x});
      end else if (out_byte !== expected_bytes[0].value ||
                   out_last !== expected_bytes[0].last) begin
        note_mismatch("wrong field", expected_bytes.pop_front());
      end else begin
        void'(expected_bytes.pop_front());
      end
    end
  end

  // Overall limit on the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, a long hold-off on request, none while calm.
  initial begin : receiver
    int unsigned roll;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else if (roll < 95) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(5, 40)) @(posedge clk);
        end
      end
    end
  end

  // Sender: directed words first, then four phases of random words.
  initial begin : sender
    stim_row_t row;
    int unsigned roll;
    int unsigned counted;

    directed_rows = '{
      '{REQ_FINISH, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'h0000_0000},
      '{REQ_LOAD,   8'h41, 32'h0000_00FF, 6'd8,  1'b1, 3'd0, 32'h0000_0000},
      '{REQ_ENCODE, 8'h41, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'hFF00_0000},
      '{REQ_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b1, 3'd0, 32'h0000_0000},
      '{REQ_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF},
      '{REQ_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0000_0000},
      '{REQ_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd4, 32'hFFFF_FFFF},
      '{REQ_LOAD,   8'h01, 32'hFFFF_FFFF, 6'd3,  1'b1, 3'd0, 32'h0000_0000},
      '{REQ_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
      '{REQ_FINISH, 8'h01, 32'h0000_0000, 6'd0,  1'b1, 3'd2, 32'hE005_0000},
      '{REQ_LOAD,   8'h02, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
      '{REQ_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
      '{REQ_UNDEF,  8'h41, 32'h0000_0000, 6'd5,  1'b1, 3'd0, 32'h0000_0000},
      '{REQ_ENCODE, 8'h41, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'hFF00_0000},
      '{REQ_LOAD,   8'h80, 32'hFFFF_FFFD, 6'd3,  1'b1, 3'd0, 32'h0000_0000},
      '{REQ_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
      '{REQ_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
      '{REQ_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
      '{REQ_FINISH, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
      '{REQ_LOAD,   8'h7F, 32'hAAAA_AAAA, 6'd33, 1'b0, 3'd0, 32'h0000_0000},
      '{REQ_ENCODE, 8'h7F, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
      '{REQ_LOAD,   8'h10, 32'h0000_0001, 6'd1,  1'b0, 3'd0, 32'h0000_0000},
      '{REQ_ENCODE, 8'h10, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
      '{REQ_FINISH, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd2, 32'h8007_0000}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: extremes, every request and the special cases.
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i]);
      rest_sender();
    end
    wait_drained();

    // Random phases: normal, receiver held off with a gapless sender,
    // no idling at all, normal again.
    for (int phase = 0; phase < 4; phase++) begin
      hold_off_req = (phase == 1);
      sender_gapless = (phase == 1);
      calm = (phase == 2);
      counted = 0;
      while (counted < WORDS_PER_PHASE) begin
        row.typed = 1'b0;
        row.n = '0;
        row.bytes = '0;
        row.sym = SYM_W'($urandom);
        row.bits = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 8) row.len = '0;
        else if (roll < 20) row.len = LEN_IN_W'($urandom_range(33, 63));
        else if (roll < 45) row.len = LEN_IN_W'($urandom_range(1, 8));
        else row.len = LEN_IN_W'($urandom_range(1, 32));
        roll = $urandom_range(0, 99);
        if (roll < 18) begin
          row.req = REQ_LOAD;
        end else if (roll < 85) begin
          // Only symbols that have been loaded are encoded.
          row.req = REQ_ENCODE;
          row.sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        end else if (roll < 95) begin
          row.req = REQ_FINISH;
        end else begin
          row.req = REQ_UNDEF;
        end
        send_word(row);
        if (row.req != REQ_UNDEF) counted++;
        rest_sender();
      end
      wait_drained();
    end

    // Let any stray byte show up before the verdict.
    sender_gapless = 1'b0;
    calm = 1'b0;
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += expected_bytes.size();
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/hcbp_pkg.sv
src/hcbp_table.sv
src/hcbp_packer.sv
src/huffman_code_bit_packer.sv
tb/tb.sv
